// ===== design/best_worst_fit_page_allocator_top_assert.svh =====
// assertion macros for the page allocator top level
// used by best_worst_fit_page_allocator_top.sv, expects clk and rst_n in scope
`ifndef BEST_WORST_FIT_PAGE_ALLOCATOR_TOP_ASSERT_SVH
`define BEST_WORST_FIT_PAGE_ALLOCATOR_TOP_ASSERT_SVH

// condition that must hold at every edge outside reset
`define BWF_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define BWF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/bwf_pkg.sv =====
// shared types and constants for the best/worst fit page allocator
// no dependencies
`default_nettype none

package bwf_pkg;

  localparam int NUM_PAGES = 32;
  localparam int ID_BITS   = 8;
  localparam int PAGE_W    = $clog2(NUM_PAGES);
  localparam int CNT_W     = $clog2(NUM_PAGES + 1);
  localparam int SIZE_W    = 12;
  localparam int NEED_W    = SIZE_W - 1;

  typedef enum logic [1:0] {
    MODE_ALLOC = 2'd0,
    MODE_FREE  = 2'd1,
    MODE_QUERY = 2'd2,
    MODE_RSVD  = 2'd3
  } op_mode_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_SIZE  = 3'd1,
    ST_ID_IN_USE = 3'd2,
    ST_NO_SPACE  = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_CHECK,
    S_FILL,
    S_DONE
  } state_t;

  typedef struct packed {
    op_mode_t           mode;
    logic [ID_BITS-1:0] prog_id;
    logic [SIZE_W-1:0]  size_kb;
  } in_item_t;

  typedef struct packed {
    status_t    status;
    logic [4:0] start_page;
    logic [5:0] page_count;
    logic [4:0] fragment_count;
  } out_item_t;

  typedef struct packed {
    logic               used;
    logic [ID_BITS-1:0] owner;
  } page_entry_t;

  typedef struct packed {
    logic             start;
    logic             step;
    logic [CNT_W-1:0] idx;
    logic             is_free_op;
  } scan_ctl_t;

  typedef struct packed {
    logic              found;
    logic [PAGE_W-1:0] first;
    logic [CNT_W-1:0]  match_cnt;
    logic              best_valid;
    logic [PAGE_W-1:0] best_start;
    logic [CNT_W-1:0]  best_len;
    logic [CNT_W-1:0]  frag;
  } scan_res_t;

endpackage

`default_nettype wire

// ===== design/bwf_page_table.sv =====
// page owner table: one used flag and one owner id per page
// one combinational read port, one write port; depends on bwf_pkg
`default_nettype none

module bwf_page_table (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [bwf_pkg::PAGE_W-1:0]  rd_addr,
  output bwf_pkg::page_entry_t             rd_data,
  input  wire logic                        wr_en,
  input  wire logic [bwf_pkg::PAGE_W-1:0]  wr_addr,
  input  wire bwf_pkg::page_entry_t        wr_data
);
  import bwf_pkg::*;

  logic [NUM_PAGES-1:0] used_r;
  logic [ID_BITS-1:0]   owner_r [NUM_PAGES];

  // used flags reset to free, owner ids only matter once a page is used
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else if (wr_en) begin
      used_r[wr_addr] <= wr_data.used;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      owner_r[wr_addr] <= wr_data.owner;
    end
  end

  assign rd_data.used  = used_r[rd_addr];
  assign rd_data.owner = owner_r[rd_addr];

endmodule

`default_nettype wire

// ===== design/bwf_scan_unit.sv =====
// shared scan unit: walks the page table one entry per cycle
// tracks free runs, best/worst fit candidate, id matches and fragment count; depends on bwf_pkg
`default_nettype none

module bwf_scan_unit (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire bwf_pkg::scan_ctl_t          ctl,
  input  wire bwf_pkg::page_entry_t        entry,
  input  wire logic [bwf_pkg::ID_BITS-1:0] id,
  input  wire logic [bwf_pkg::NEED_W-1:0]  need,
  input  wire logic                        policy,
  output logic                             match,
  output bwf_pkg::scan_res_t               res
);
  import bwf_pkg::*;

  logic              in_run_r;
  logic [PAGE_W-1:0] run_start_r;
  logic              prev_free_r;
  scan_res_t         res_r;

  logic             at_end;
  logic             pg_free;
  logic             new_free;
  logic             closing;
  logic [CNT_W-1:0] run_len;
  logic             fits;
  logic             better;

  always_comb begin
    at_end   = (ctl.idx == CNT_W'(NUM_PAGES));
    pg_free  = !at_end && !entry.used;
    match    = !at_end && entry.used && (entry.owner == id);
    // page state as it stands after a free has cleared the matching pages
    new_free = pg_free || (ctl.is_free_op && match);
    closing  = !pg_free && in_run_r;
    run_len  = ctl.idx - CNT_W'(run_start_r);
    fits     = NEED_W'(run_len) >= need;
    if (!res_r.best_valid) begin
      better = 1'b1;
    end else if (policy) begin
      better = run_len > res_r.best_len;
    end else begin
      better = run_len < res_r.best_len;
    end
  end

  // run start, best candidate and first match are only read behind their flags
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.start) begin
      in_run_r         <= 1'b0;
      prev_free_r      <= 1'b0;
      res_r.found      <= 1'b0;
      res_r.match_cnt  <= '0;
      res_r.best_valid <= 1'b0;
      res_r.frag       <= '0;
    end else if (ctl.step) begin
      prev_free_r <= new_free;
      if (new_free && !prev_free_r) begin
        res_r.frag <= res_r.frag + 1'b1;
      end
      if (pg_free && !in_run_r) begin
        in_run_r    <= 1'b1;
        run_start_r <= ctl.idx[PAGE_W-1:0];
      end else if (closing) begin
        in_run_r <= 1'b0;
        if (fits && better) begin
          res_r.best_valid <= 1'b1;
          res_r.best_start <= run_start_r;
          res_r.best_len   <= run_len;
        end
      end
      if (match) begin
        res_r.found     <= 1'b1;
        res_r.match_cnt <= res_r.match_cnt + 1'b1;
        if (!res_r.found) begin
          res_r.first <= ctl.idx[PAGE_W-1:0];
        end
      end
    end
  end

  assign res = res_r;

endmodule

`default_nettype wire

// ===== design/best_worst_fit_page_allocator_top.sv =====
// Contiguous page allocator over 32 pages with best or worst fit placement.
// Input channel in_valid/in_ready/in_item carries one request transaction:
// allocate (id, size in KB, ceil(size/4) pages), free by id, or query.
// Output channel out_valid/out_ready/out_item returns one result per request:
// status, start page, page count and the number of free runs afterwards.
// cfg_we/cfg_wdata set the fit policy (0 best fit, 1 worst fit), write only.
// Each request runs one pass of the shared scan unit over the page table,
// one entry per cycle, then a check state and a done state that loads the
// result register; a successful allocate writes its pages in a fill state between them.
// out_valid rises once the done state has loaded the result; a new request is
// taken only once the block returns to idle, so it holds one request at a time.
// in_ready is high only while idle; it may be high while a result still waits
// in the output register. If the receiver stalls, a finished result is held
// until the register frees up, and no further request is taken meanwhile.
// Reset (rst_n low, synchronous) marks every page free, selects best fit and
// empties the output register.
`default_nettype none

module best_worst_fit_page_allocator_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire bwf_pkg::in_item_t in_item,
  output logic             out_valid,
  input  wire logic        out_ready,
  output bwf_pkg::out_item_t out_item,
  input  wire logic        cfg_we,
  input  wire logic        cfg_wdata
);
  import bwf_pkg::*;

  state_t            state_r, state_nxt;
  in_item_t          item_r;
  logic [NEED_W-1:0] need_r, need_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [PAGE_W-1:0] fill_addr_r, fill_addr_nxt;
  logic [CNT_W-1:0]  fill_left_r, fill_left_nxt;
  logic              policy_r;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_item_r, out_item_nxt;

  logic              accept;
  logic [SIZE_W:0]   size_sum;
  scan_ctl_t         scan_ctl;
  page_entry_t       rd_data;
  page_entry_t       wr_data;
  logic              wr_en;
  logic [PAGE_W-1:0] wr_addr;
  logic              match;
  scan_res_t         res;
  logic              alloc_ok;
  out_item_t         result;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign size_sum  = {1'b0, in_item.size_kb} + (SIZE_W + 1)'(3);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  bwf_page_table u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (idx_r[PAGE_W-1:0]),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  bwf_scan_unit u_scan (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (scan_ctl),
    .entry  (rd_data),
    .id     (item_r.prog_id),
    .need   (need_r),
    .policy (policy_r),
    .match  (match),
    .res    (res)
  );

  assign alloc_ok = (item_r.mode == MODE_ALLOC) && (item_r.size_kb != '0) &&
                    !res.found && res.best_valid;

  // result of the finished transaction
  always_comb begin
    result = '0;
    result.status         = ST_OK;
    result.fragment_count = 5'(res.frag);
    case (item_r.mode)
      MODE_ALLOC: begin
        if (item_r.size_kb == '0) begin
          result.status = ST_BAD_SIZE;
        end else if (res.found) begin
          result.status = ST_ID_IN_USE;
        end else if (!res.best_valid) begin
          result.status = ST_NO_SPACE;
        end else begin
          result.start_page = 5'(res.best_start);
          result.page_count = 6'(need_r);
          // taking a whole run removes one fragment
          if (NEED_W'(res.best_len) == need_r) begin
            result.fragment_count = 5'(res.frag - 1'b1);
          end
        end
      end
      MODE_FREE: begin
        if (res.found) begin
          result.start_page = 5'(res.first);
          result.page_count = 6'(res.match_cnt);
        end else begin
          result.status = ST_NOT_FOUND;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    need_nxt      = need_r;
    idx_nxt       = idx_r;
    fill_addr_nxt = fill_addr_r;
    fill_left_nxt = fill_left_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_item_nxt  = out_item_r;
    scan_ctl.start      = accept;
    scan_ctl.step       = 1'b0;
    scan_ctl.idx        = idx_r;
    scan_ctl.is_free_op = (item_r.mode == MODE_FREE);
    wr_en   = 1'b0;
    wr_addr = idx_r[PAGE_W-1:0];
    wr_data = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          need_nxt  = size_sum[SIZE_W:2];
          idx_nxt   = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        scan_ctl.step = 1'b1;
        // a free clears each matching page as the scan passes it
        wr_en = scan_ctl.is_free_op && match;
        idx_nxt = idx_r + 1'b1;
        if (idx_r == CNT_W'(NUM_PAGES)) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (alloc_ok) begin
          fill_addr_nxt = res.best_start;
          fill_left_nxt = CNT_W'(need_r);
          state_nxt     = S_FILL;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_FILL: begin
        wr_en         = 1'b1;
        wr_addr       = fill_addr_r;
        wr_data.used  = 1'b1;
        wr_data.owner = item_r.prog_id;
        fill_addr_nxt = fill_addr_r + 1'b1;
        fill_left_nxt = fill_left_r - 1'b1;
        if (fill_left_r == CNT_W'(1)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = result;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      policy_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        policy_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
    need_r      <= need_nxt;
    idx_r       <= idx_nxt;
    fill_addr_r <= fill_addr_nxt;
    fill_left_r <= fill_left_nxt;
    out_item_r  <= out_item_nxt;
  end

`include "best_worst_fit_page_allocator_top_assert.svh"

  `BWF_ASSERT_ALWAYS(a_fill_only_alloc,
    (state_r != S_FILL) || ((item_r.mode == MODE_ALLOC) && res.best_valid && !res.found),
    "page fill outside a valid allocate")
  `BWF_ASSERT_ALWAYS(a_fill_in_range,
    (state_r != S_FILL) || ((fill_left_r != '0) &&
    ((CNT_W + 1)'(fill_addr_r) + (CNT_W + 1)'(fill_left_r) <= (CNT_W + 1)'(NUM_PAGES))),
    "page fill runs past the table")
  `BWF_ASSERT_NEXT(a_check_to_fill, (state_r == S_CHECK) && alloc_ok, state_r == S_FILL,
    "successful allocate skipped the fill")
  `BWF_ASSERT_ALWAYS(a_frag_bound,
    !out_valid_r || (out_item_r.fragment_count <= 5'(NUM_PAGES / 2)),
    "fragment count above half the pages")

endmodule

`default_nettype wire

// ===== sim/tb_best_worst_fit_page_allocator_top.sv =====
// testbench for best_worst_fit_page_allocator_top: directed and random requests
// checked against a page table tracker under both fit policies
// depends on bwf_pkg and the allocator top level in design/
`timescale 1ns / 1ps

module tb_best_worst_fit_page_allocator_top;
  import bwf_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 80;
  localparam int RAND_PHASE  = 133;
  localparam int MAX_REPORTS = 40;

  // tracks page ownership and the results the block should return
  class alloc_tracker;
    page_entry_t page_tab[NUM_PAGES];
    logic        fit_worst;
    out_item_t   pending_results[$];
    int unsigned errors;
    int unsigned n_req, n_placed, n_freed, n_rejected, n_checked;

    function void clear();
      foreach (page_tab[p]) page_tab[p] = '0;
      fit_worst = 1'b0;
    endfunction

    function int unsigned free_runs();
      int unsigned n;
      n = 0;
      for (int p = 0; p < NUM_PAGES; p++)
        if (!page_tab[p].used && (p == 0 || page_tab[p-1].used)) n++;
      return n;
    endfunction

    function bit owns_pages(logic [ID_BITS-1:0] id);
      foreach (page_tab[p])
        if (page_tab[p].used && page_tab[p].owner == id) return 1'b1;
      return 1'b0;
    endfunction

    function out_item_t place_or_release(in_item_t req);
      out_item_t res;
      int        need;
      int        pick_start;
      int        pick_len;
      int        run_start;
      int        run_len;
      bit        is_free;
      bit        take;
      bit        found;
      res = '0;
      res.status = ST_OK;
      case (req.mode)
        MODE_ALLOC: begin
          if (req.size_kb == '0) begin
            res.status = ST_BAD_SIZE;
          end else if (owns_pages(req.prog_id)) begin
            res.status = ST_ID_IN_USE;
          end else begin
            need = (int'(req.size_kb) + 3) / 4;
            pick_start = -1;
            pick_len = 0;
            run_start = -1;
            // walk one past the end so a run touching the top page closes
            for (int p = 0; p <= NUM_PAGES; p++) begin
              is_free = 1'b0;
              if (p < NUM_PAGES) is_free = !page_tab[p].used;
              if (is_free) begin
                if (run_start < 0) run_start = p;
              end else if (run_start >= 0) begin
                run_len = p - run_start;
                if (run_len >= need) begin
                  if (pick_start < 0) take = 1'b1;
                  else if (!fit_worst) take = run_len < pick_len;
                  else take = run_len > pick_len;
                  if (take) begin
                    pick_start = run_start;
                    pick_len = run_len;
                  end
                end
                run_start = -1;
              end
            end
            if (pick_start < 0) begin
              res.status = ST_NO_SPACE;
            end else begin
              for (int p = pick_start; p < pick_start + need; p++)
                page_tab[p] = '{used: 1'b1, owner: req.prog_id};
              res.start_page = 5'(pick_start);
              res.page_count = 6'(need);
            end
          end
        end
        MODE_FREE: begin
          found = 1'b0;
          for (int p = 0; p < NUM_PAGES; p++) begin
            if (page_tab[p].used && page_tab[p].owner == req.prog_id) begin
              if (!found) res.start_page = 5'(p);
              found = 1'b1;
              res.page_count = res.page_count + 6'd1;
              page_tab[p] = '0;
            end
          end
          if (!found) res.status = ST_NOT_FOUND;
        end
        default: ;
      endcase
      if (res.status != ST_OK) begin
        res.start_page = '0;
        res.page_count = '0;
      end
      res.fragment_count = 5'(free_runs());
      return res;
    endfunction

    function void note_request(in_item_t req);
      out_item_t res;
      res = place_or_release(req);
      n_req++;
      if (res.status != ST_OK) n_rejected++;
      else if (req.mode == MODE_ALLOC) n_placed++;
      else if (req.mode == MODE_FREE) n_freed++;
      pending_results.push_back(res);
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    task report(string msg);
      if (errors < MAX_REPORTS) $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result transaction status=%0d start=%0d count=%0d frag=%0d",
                         got.status, got.start_page, got.page_count, got.fragment_count));
        return;
      end
      want = pending_results.pop_front();
      n_checked++;
      if (got.status !== want.status)
        report($sformatf("result %0d status got %0d want %0d", n_checked, got.status,
                         want.status));
      if (got.start_page !== want.start_page)
        report($sformatf("result %0d start_page got %0d want %0d", n_checked,
                         got.start_page, want.start_page));
      if (got.page_count !== want.page_count)
        report($sformatf("result %0d page_count got %0d want %0d", n_checked,
                         got.page_count, want.page_count));
      if (got.fragment_count !== want.fragment_count)
        report($sformatf("result %0d fragment_count got %0d want %0d", n_checked,
                         got.fragment_count, want.fragment_count));
    endtask
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_item;
  logic      cfg_we;
  logic      cfg_wdata;

  alloc_tracker sb = new;
  bit           idling_on;
  int unsigned  stall_left;
  int unsigned  cycle_count;

  best_worst_fit_page_allocator_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, sb.pending());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // result side: random stall bursts while idling is on
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready = 1'b0;
      stall_left--;
    end else begin
      out_ready = 1'b1;
      if (idling_on && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 14);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_item);
  end

  function automatic in_item_t make_req(op_mode_t m, int id, int kb);
    in_item_t r;
    r.mode = m;
    r.prog_id = ID_BITS'(id);
    r.size_kb = SIZE_W'(kb);
    return r;
  endfunction

  function automatic in_item_t random_req();
    in_item_t r;
    int       sel;
    int       pick;
    sel = $urandom_range(0, 99);
    if (sel < 50) r.mode = MODE_ALLOC;
    else if (sel < 85) r.mode = MODE_FREE;
    else if (sel < 95) r.mode = MODE_QUERY;
    else r.mode = MODE_RSVD;
    // a small id pool keeps frees hitting and allocations colliding
    if ($urandom_range(0, 4) == 0) r.prog_id = ID_BITS'($urandom_range(0, 255));
    else r.prog_id = ID_BITS'($urandom_range(0, 11));
    pick = $urandom_range(0, 19);
    if (pick == 0) r.size_kb = '0;
    else if (pick == 1) r.size_kb = SIZE_W'($urandom_range(0, 4095));
    else if (pick == 2) r.size_kb = SIZE_W'($urandom_range(33, 128));
    else r.size_kb = SIZE_W'($urandom_range(1, 24));
    return r;
  endfunction

  task automatic send_request(input in_item_t req);
    if (idling_on && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 14)) begin
        @(negedge clk);
        in_valid = 1'b0;
      end
    @(negedge clk);
    in_valid = 1'b1;
    in_item = req;
    do @(posedge clk); while (!in_ready);
    sb.note_request(req);
  endtask

  // drop valid and wait for every outstanding result, then let the block go idle
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_policy(input logic worst);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = worst;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.fit_worst = worst;
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    idling_on = 1'b1;
    stall_left = 0;
    cycle_count = 0;
    sb.clear();
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    write_policy(1'b0);
    send_request(make_req(MODE_QUERY, 0, 0));
    send_request(make_req(MODE_RSVD, 255, 4095));
    send_request(make_req(MODE_ALLOC, 0, 0));       // zero size
    send_request(make_req(MODE_ALLOC, 255, 4095));  // more pages than exist
    send_request(make_req(MODE_ALLOC, 1, 128));     // whole table
    send_request(make_req(MODE_ALLOC, 2, 1));       // table full
    send_request(make_req(MODE_ALLOC, 1, 4));       // id already owns pages
    send_request(make_req(MODE_ALLOC, 1, 0));       // zero size wins over id in use
    send_request(make_req(MODE_FREE, 1, 0));
    send_request(make_req(MODE_FREE, 1, 0));        // unknown id
    send_request(make_req(MODE_ALLOC, 0, 5));
    send_request(make_req(MODE_ALLOC, 255, 8));
    send_request(make_req(MODE_ALLOC, 3, 12));
    send_request(make_req(MODE_ALLOC, 4, 4));
    send_request(make_req(MODE_FREE, 255, 0));
    send_request(make_req(MODE_FREE, 3, 0));        // merges with the hole beside it
    send_request(make_req(MODE_ALLOC, 5, 4));       // best fit takes the small hole
    drain();
    write_policy(1'b1);
    send_request(make_req(MODE_ALLOC, 6, 4));       // worst fit takes the big run
    send_request(make_req(MODE_FREE, 0, 0));
    send_request(make_req(MODE_QUERY, 9, 77));
    send_request(make_req(MODE_ALLOC, 7, 4095));
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      write_policy(phase[0]);
      // no idling on either side in the last phase
      if (phase == 3) idling_on = 1'b0;
      repeat (RAND_PHASE) send_request(random_req());
      drain();
    end

    if (sb.pending() != 0) sb.report("results still outstanding at end of run");
    $display("ran %0d requests under best and worst fit: %0d placed, %0d released,",
             sb.n_req, sb.n_placed, sb.n_freed);
    $display("%0d rejected, %0d results checked", sb.n_rejected, sb.n_checked);
    if (sb.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
